// ----- rtl/core/dlpd_pkg.sv -----
// Shared types and constants for the decimal length-prefix deframer.
`default_nettype none

package dlpd_pkg;

    // Default width of the length counter
    localparam int unsigned LEN_WIDTH_DEF = 32;

    // Width of the max_length register
    localparam int unsigned MAX_LEN_W = 32;

    // Reset value of max_length
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = '1;

    // ASCII characters used by the header parser
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Parser phase
    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CLOSED  = 2'd3
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_BAD_START = 2'd1,
        KIND_BAD_SEP   = 2'd2,
        KIND_TOO_LONG  = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// ----- rtl/core/decimal_length_prefix_deframer_core.sv -----
// Decimal length-prefix deframer: header parser, payload counter and result register.
//
// Input channel (in_valid/in_ready/in_byte) takes raw link bytes forming frames
// "<decimal length>:<payload>". Output channel (out_valid/out_ready) gives one
// request per payload byte (out_kind = data, out_last on the final byte) or a
// single error request (bad start byte, bad separator, length too large).
// Header bytes and bytes after an error give no request.
// cfg_valid/cfg_ready/cfg_data write max_length; write it only while idle.
// Path: a byte accepted goes into the input register, then through one step of
// compare and multiply-by-ten add into the output register. Throughput: one
// byte per cycle while the receiver does not stall, set by that single step.
// The input register refills in the same cycle the output register drains,
// so a byte can be taken while a finished result waits to be taken.
// When the receiver stalls, the output register holds its request and the
// input register holds one byte; in_ready drops once both are occupied.
// After an error the parser is closed: bytes are still accepted but dropped.
// Reset: parser expects a first length digit, both registers empty,
// max_length set to all ones. The limit in force is the smaller of
// max_length and the largest value the LEN_WIDTH counter holds.
`default_nettype none

module decimal_length_prefix_deframer_core #(
    parameter int unsigned LEN_WIDTH = dlpd_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dlpd_pkg::MAX_LEN_W-1:0] cfg_data,
    // byte input
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     in_byte,
    // results
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          out_kind,
    output logic [7:0]                          out_byte,
    output logic                                out_last
);

    // Sum of ten times the count plus a digit needs four extra bits
    localparam int unsigned SUM_W = LEN_WIDTH + 4;
    localparam int unsigned CMP_W = (SUM_W > dlpd_pkg::MAX_LEN_W) ? SUM_W
                                                                   : dlpd_pkg::MAX_LEN_W;

    dlpd_pkg::phase_t              phase_reg, phase_next;
    logic [LEN_WIDTH-1:0]          count_reg, count_next;
    logic [dlpd_pkg::MAX_LEN_W-1:0] max_len_reg;

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;

    logic                          out_valid_reg;
    dlpd_pkg::kind_t               out_kind_reg;
    logic [7:0]                    out_byte_reg;
    logic                          out_last_reg;

    logic                          out_free;
    logic                          advance;

    logic                          res_valid;
    dlpd_pkg::kind_t               res_kind;
    logic [7:0]                    res_byte;
    logic                          res_last;

    logic                          is_digit;
    logic                          is_start;
    logic [3:0]                    digit_full;
    logic [LEN_WIDTH-1:0]          acc_base;
    logic [SUM_W-1:0]              base_ext;
    logic [SUM_W-1:0]              acc_sum;
    logic                          too_long;
    logic [LEN_WIDTH-1:0]          count_dec;

    // Handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Digit decode and accumulate: count * 10 + d, checked against the limit
    assign is_digit   = (in_byte_reg >= dlpd_pkg::CH_ZERO) && (in_byte_reg <= dlpd_pkg::CH_NINE);
    assign is_start   = (in_byte_reg >= dlpd_pkg::CH_ONE) && (in_byte_reg <= dlpd_pkg::CH_NINE);
    assign digit_full = 4'(in_byte_reg - dlpd_pkg::CH_ZERO);
    assign acc_base   = (phase_reg == dlpd_pkg::PH_FIRST) ? '0 : count_reg;
    assign base_ext   = SUM_W'(acc_base);
    assign acc_sum    = (base_ext << 3) + (base_ext << 1) + SUM_W'(digit_full);
    assign too_long   = (acc_sum[SUM_W-1:LEN_WIDTH] != '0)
                     || (CMP_W'(acc_sum) > CMP_W'(max_len_reg));
    assign count_dec  = count_reg - LEN_WIDTH'(1);

    // Parser state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dlpd_pkg::PH_FIRST;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res_kind   = dlpd_pkg::KIND_DATA;
        res_byte   = '0;
        res_last   = 1'b0;
        if (advance)
        begin
            unique case (phase_reg)
                dlpd_pkg::PH_FIRST:
                begin
                    if (!is_start)
                    begin
                        phase_next = dlpd_pkg::PH_CLOSED;
                        count_next = '0;
                        res_valid  = 1'b1;
                        res_kind   = dlpd_pkg::KIND_BAD_START;
                    end
                    else if (too_long)
                    begin
                        phase_next = dlpd_pkg::PH_CLOSED;
                        count_next = '0;
                        res_valid  = 1'b1;
                        res_kind   = dlpd_pkg::KIND_TOO_LONG;
                    end
                    else
                    begin
                        phase_next = dlpd_pkg::PH_DIGITS;
                        count_next = acc_sum[LEN_WIDTH-1:0];
                    end
                end
                dlpd_pkg::PH_DIGITS:
                begin
                    priority if (is_digit && too_long)
                    begin
                        phase_next = dlpd_pkg::PH_CLOSED;
                        count_next = '0;
                        res_valid  = 1'b1;
                        res_kind   = dlpd_pkg::KIND_TOO_LONG;
                    end
                    else if (is_digit)
                    begin
                        count_next = acc_sum[LEN_WIDTH-1:0];
                    end
                    else if (in_byte_reg == dlpd_pkg::CH_COLON)
                    begin
                        phase_next = dlpd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = dlpd_pkg::PH_CLOSED;
                        count_next = '0;
                        res_valid  = 1'b1;
                        res_kind   = dlpd_pkg::KIND_BAD_SEP;
                    end
                end
                dlpd_pkg::PH_PAYLOAD:
                begin
                    count_next = count_dec;
                    res_valid  = 1'b1;
                    res_byte   = in_byte_reg;
                    if (count_dec == '0)
                    begin
                        phase_next = dlpd_pkg::PH_FIRST;
                        res_last   = 1'b1;
                    end
                end
                dlpd_pkg::PH_CLOSED:
                begin
                    // closed until reset: byte dropped
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= dlpd_pkg::MAX_LEN_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= in_byte;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_decimal_length_prefix_deframer_core.sv -----
// Self-checking testbench for the decimal length-prefix deframer core.
`default_nettype none

module tb_decimal_length_prefix_deframer_core;

    import dlpd_pkg::*;

    localparam int unsigned LEN_W      = LEN_WIDTH_DEF;
    localparam logic [63:0] LEN_MASK   = {64{1'b1}} >> (64 - LEN_W);
    localparam int unsigned ITEMS      = 1450;
    localparam int unsigned SETTLE     = 8;
    localparam int unsigned DRAIN      = 20;
    localparam int unsigned WD_LIMIT   = 2000;

    // Link-side requests: a raw byte, a max_length write, or a hold-off
    typedef enum logic [1:0] {
        REQ_BYTE,
        REQ_CFG,
        REQ_PAUSE
    } link_op_t;

    typedef struct {
        link_op_t    op;
        logic [31:0] val;
    } link_req_t;

    // One deframed result
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } deframed_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        out_last;

    link_req_t   link_q[$];
    deframed_t   deframed_q[$];

    // Shadow of the parser state
    phase_t      hdr_phase = PH_FIRST;
    logic [63:0] len_count = '0;
    logic [31:0] max_len   = MAX_LEN_RESET;

    int unsigned tx_gap, rx_stall, quiet_cycles, idle_wd, err_cnt;
    bit          tx_calm, rx_calm, in_busy, cfg_busy;
    deframed_t   want;

    decimal_length_prefix_deframer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------

    // Header fault: one error result, then the parser stays shut
    function automatic void reject(kind_t k);
        hdr_phase = PH_CLOSED;
        len_count = '0;
        deframed_q.push_back('{kind: k, data: 8'h00, last: 1'b0});
    endfunction

    // Multiply-by-ten add, refused if the length would pass the limit
    function automatic bit take_digit(logic [63:0] d);
        logic [63:0] lim;
        lim = ({32'd0, max_len} < LEN_MASK) ? {32'd0, max_len} : LEN_MASK;
        if (d > lim || len_count > (lim - d) / 10)
            return 1'b0;
        len_count = (len_count * 10 + d) & LEN_MASK;
        return 1'b1;
    endfunction

    function automatic void deframe_step(logic [7:0] b);
        case (hdr_phase)
            PH_FIRST:
            begin
                if (b < CH_ONE || b > CH_NINE)
                    reject(KIND_BAD_START);
                else
                begin
                    len_count = '0;
                    if (!take_digit(64'(b - CH_ZERO)))
                        reject(KIND_TOO_LONG);
                    else
                        hdr_phase = PH_DIGITS;
                end
            end
            PH_DIGITS:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (!take_digit(64'(b - CH_ZERO)))
                        reject(KIND_TOO_LONG);
                end
                else if (b == CH_COLON)
                    hdr_phase = PH_PAYLOAD;
                else
                    reject(KIND_BAD_SEP);
            end
            PH_PAYLOAD:
            begin
                len_count = (len_count - 1) & LEN_MASK;
                deframed_q.push_back('{kind: KIND_DATA, data: b, last: (len_count == 0)});
                if (len_count == 0)
                    hdr_phase = PH_FIRST;
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, a few long ones, none while calm
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus queue builders
    // ---------------------------------------------------------------

    int unsigned n_items;

    task automatic push_byte(logic [7:0] b);
        link_q.push_back('{op: REQ_BYTE, val: {24'd0, b}});
        n_items++;
    endtask

    task automatic push_cfg(logic [31:0] v);
        link_q.push_back('{op: REQ_CFG, val: v});
    endtask

    task automatic push_pause();
        link_q.push_back('{op: REQ_PAUSE, val: '0});
    endtask

    // Decimal length digits; optionally retune the limit after the first digit
    task automatic push_header(longint unsigned v, bit retune, logic [31:0] new_max);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
            if (i == 0 && retune)
                push_cfg(new_max);
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: link bytes and limit writes
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            in_byte      <= '0;
            cfg_valid    <= 1'b0;
            cfg_data     <= '0;
            tx_gap       <= 0;
            tx_calm      <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_busy  = in_valid && !in_ready;
            cfg_busy = cfg_valid && !cfg_ready;
            if (in_valid && in_ready)
                deframe_step(in_byte);
            if (cfg_valid && cfg_ready)
                max_len = cfg_data;

            // idle once nothing is owed and nothing is offered
            if (deframed_q.size() != 0 || in_valid || cfg_valid)
                quiet_cycles <= 0;
            else if (quiet_cycles < SETTLE)
                quiet_cycles <= quiet_cycles + 1;

            if (!in_busy && !cfg_busy)
            begin
                if (tx_gap != 0)
                    tx_gap <= tx_gap - 1;
                else if (link_q.size() != 0)
                begin
                    case (link_q[0].op)
                        REQ_BYTE:
                        begin
                            in_byte <= link_q[0].val[7:0];
                            in_busy = 1'b1;
                            void'(link_q.pop_front());
                            tx_gap <= pick_gap(tx_calm);
                            if ($urandom_range(0, tx_calm ? 39 : 149) == 0)
                                tx_calm <= !tx_calm;
                        end
                        REQ_CFG:
                        begin
                            if (quiet_cycles >= SETTLE)
                            begin
                                cfg_data <= link_q[0].val;
                                cfg_busy = 1'b1;
                                void'(link_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= SETTLE)
                            begin
                                void'(link_q.pop_front());
                                tx_gap <= $urandom_range(5, 40);
                            end
                        end
                    endcase
                end
            end
            in_valid  <= in_busy;
            cfg_valid <= cfg_busy;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: result checks and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
            rx_calm   <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $error("unexpected request: out_kind %0d out_byte %02h out_last %0b",
                           out_kind, out_byte, out_last);
                    err_cnt++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (out_kind !== want.kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
                        err_cnt++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        err_cnt++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", want.last, out_last);
                        err_cnt++;
                    end
                end
            end

            if (rx_stall != 0)
            begin
                out_ready <= 1'b0;
                rx_stall  <= rx_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_stall <= pick_gap(rx_calm);
                if ($urandom_range(0, rx_calm ? 39 : 149) == 0)
                    rx_calm <= !rx_calm;
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
                idle_wd <= 0;
            else
                idle_wd <= idle_wd + 1;
            if (idle_wd == WD_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        logic [31:0]     cur_max;
        logic [31:0]     new_max;
        logic [7:0]      b;
        int unsigned     len;
        int unsigned     r;
        bit              retune;
        longint unsigned v;

        // directed: payload extremes, exact limit with a zero digit, limit of one
        push_cfg(32'd10);
        push_header(1, 1'b0, '0);
        push_byte(CH_COLON);
        push_byte(8'h00);
        push_header(3, 1'b0, '0);
        push_byte(CH_COLON);
        push_byte(8'hFF);
        push_byte(CH_COLON);
        push_byte(CH_NINE);
        push_header(10, 1'b0, '0);
        push_byte(CH_COLON);
        for (int i = 0; i < 10; i++)
            push_byte(8'(i * 29 + 11));
        push_cfg(32'd1);
        push_header(1, 1'b0, '0);
        push_byte(CH_COLON);
        push_byte(8'hA5);
        push_cfg(32'hFFFF_FFFF);
        cur_max = 32'hFFFF_FFFF;

        // random well-formed frames, limit changes between and inside headers
        while (n_items < ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       cur_max = 32'd1;
                    1:       cur_max = 32'hFFFF_FFFF;
                    2:       cur_max = $urandom_range(1, 40);
                    3:       cur_max = $urandom_range(41, 400);
                    default: cur_max = $urandom | 32'd1;
                endcase
                push_cfg(cur_max);
            end
            if ($urandom_range(0, 39) == 0)
                push_pause();

            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 300);
            len = 1 + (len - 1) % cur_max;

            retune  = (len >= 10) && ($urandom_range(0, 2) == 0);
            new_max = $urandom_range(0, 1) ? 32'hFFFF_FFFF : len + $urandom_range(0, 20);
            push_header(len, retune, new_max);
            if (retune)
                cur_max = new_max;
            push_byte(CH_COLON);
            repeat (len)
                push_byte($urandom_range(0, 255));
        end

        // one closing fault, chosen at random since only one reset is allowed
        push_pause();
        case ($urandom_range(0, 4))
            0:
            begin
                // bad start byte
                if ($urandom_range(0, 1) == 0)
                    b = $urandom_range(0, 1) ? CH_ZERO : CH_COLON;
                else
                begin
                    do
                        b = $urandom_range(0, 255);
                    while (b >= CH_ONE && b <= CH_NINE);
                end
                push_byte(b);
            end
            1:
            begin
                // bad separator after a valid length
                v = (cur_max < 999) ? $urandom_range(1, cur_max) : $urandom_range(1, 999);
                push_header(v, 1'b0, '0);
                do
                    b = $urandom_range(0, 255);
                while (b >= CH_ZERO && b <= CH_COLON);
                push_byte(b);
            end
            2:
            begin
                // length just above a small limit
                new_max = $urandom_range(1, 300);
                push_cfg(new_max);
                push_header(new_max + $urandom_range(1, 50), 1'b0, '0);
            end
            3:
            begin
                // limit of zero rejects the first digit
                push_cfg(32'd0);
                push_byte(CH_ONE + 8'($urandom_range(0, 8)));
            end
            default:
            begin
                // one past the full 32-bit range
                push_cfg(32'hFFFF_FFFF);
                push_header(64'd4294967296, 1'b0, '0);
            end
        endcase

        // parser is shut: these must all be dropped
        repeat (30)
        begin
            if ($urandom_range(0, 1) == 0)
                push_byte(CH_ZERO + 8'($urandom_range(0, 10)));
            else
                push_byte($urandom_range(0, 255));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (link_q.size() != 0 || in_valid || cfg_valid || deframed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/dlpd_pkg.sv
rtl/core/decimal_length_prefix_deframer_core.sv
verif/tb_decimal_length_prefix_deframer_core.sv
